>>> src/ile_pkg.sv
// ile_pkg: shared widths, command and status codes, and the result type
// of the indexed list engine
// no dependencies
package ile_pkg;

    localparam int CMD_W    = 3;
    localparam int POS_W    = 11;
    localparam int DATA_W   = 32;
    localparam int LEN_W    = 11;
    localparam int STATUS_W = 2;

    localparam logic [CMD_W-1:0] CMD_GET    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_HEAD   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_TAIL   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    localparam logic [DATA_W-1:0] MISS_DATA = {DATA_W{1'b1}};

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic                     hit;
        logic [STATUS_W-1:0]      status;
        logic [LEN_W-1:0]         length;
    } res_t;

endpackage

>>> src/indexed_list_engine.sv
// indexed_list_engine: ordered list of 32-bit values in a linked store
// top level; depends on ile_pkg, ile_ram, ile_seq
//
// input channel (in_valid/in_ready) takes one item: cmd, position, data_in.
// output channel (out_valid/out_ready) gives one result per item: data_out,
// hit, status and the list length after the command.
// one item is worked on at a time; in_ready is high only while the
// sequencer is idle. a finished result sits in the output register, so the
// next item is taken while the receiver has not yet taken the last one.
// rejected and unused commands pass from S_START straight to S_RESP; add
// at head, insert at 0 and add at tail to an empty list pass through S_POP;
// get at position p walks p links in S_WALK; insert at p > 0, add at tail
// to a nonempty list and delete at p also walk, then fix links in S_FIX.
// with out_ready high the sequencer returns to idle as out_valid rises, so
// the next item can be taken at once. the walk down the link ram, one link
// read per cycle, sets how long an item takes.
// reset empties the list at once: the free chain through all slots is
// implied by a fill mark, so no clearing pass runs and items are accepted
// as soon as reset ends. while the receiver stalls, the result is
// held and a following item waits in the sequencer before its result.
module indexed_list_engine
    import ile_pkg::*;
#(
    parameter int CAPACITY = 1024
)(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [CMD_W-1:0]         cmd,
    input  logic [POS_W-1:0]         position,
    input  logic signed [DATA_W-1:0] data_in,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] data_out,
    output logic                     hit,
    output logic [STATUS_W-1:0]      status,
    output logic [LEN_W-1:0]         length
);

    localparam int SW = $clog2(CAPACITY);

    logic              res_valid;
    logic              res_ready;
    res_t              res;
    logic              link_we;
    logic [SW-1:0]     link_waddr;
    logic [SW-1:0]     link_wdata;
    logic              link_re;
    logic [SW-1:0]     link_raddr;
    logic [SW-1:0]     link_rdata;
    logic              value_we;
    logic [SW-1:0]     value_waddr;
    logic [DATA_W-1:0] value_wdata;
    logic [DATA_W-1:0] value_rdata;

    logic out_valid_reg, out_valid_next;
    res_t out_reg;

    ile_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .position    (position),
        .data_in     (data_in),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .link_we     (link_we),
        .link_waddr  (link_waddr),
        .link_wdata  (link_wdata),
        .link_re     (link_re),
        .link_raddr  (link_raddr),
        .link_rdata  (link_rdata),
        .value_we    (value_we),
        .value_waddr (value_waddr),
        .value_wdata (value_wdata),
        .value_rdata (value_rdata)
    );

    ile_ram #(
        .WIDTH (SW),
        .DEPTH (CAPACITY)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .re    (link_re),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    // value ram follows the link ram read address
    ile_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_value_ram (
        .clk   (clk),
        .we    (value_we),
        .waddr (value_waddr),
        .wdata (value_wdata),
        .re    (link_re),
        .raddr (link_raddr),
        .rdata (value_rdata)
    );

    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign data_out  = out_reg.data;
    assign hit       = out_reg.hit;
    assign status    = out_reg.status;
    assign length    = out_reg.length;

endmodule

>>> src/ile_ram.sv
// ile_ram: generic single write port, single read port ram with registered read
// no dependencies
module ile_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/ile_seq.sv
// ile_seq: command sequencer of the indexed list engine; walks the link ram,
// keeps head, free chain, length and the fill mark of never used slots
// depends on ile_pkg
module ile_seq
    import ile_pkg::*;
#(
    parameter int CAPACITY = 1024,
    localparam int SW = $clog2(CAPACITY),
    localparam int CW = $clog2(CAPACITY + 1)
)(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [CMD_W-1:0]         cmd,
    input  logic [POS_W-1:0]         position,
    input  logic signed [DATA_W-1:0] data_in,
    output logic                     res_valid,
    input  logic                     res_ready,
    output res_t                     res,
    output logic                     link_we,
    output logic [SW-1:0]            link_waddr,
    output logic [SW-1:0]            link_wdata,
    output logic                     link_re,
    output logic [SW-1:0]            link_raddr,
    input  logic [SW-1:0]            link_rdata,
    output logic                     value_we,
    output logic [SW-1:0]            value_waddr,
    output logic [DATA_W-1:0]        value_wdata,
    input  logic [DATA_W-1:0]        value_rdata
);

    localparam int LW = (CW > POS_W) ? CW : POS_W;
    localparam logic [SW-1:0] LAST_SLOT  = SW'(CAPACITY - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_POP   = 3'd2;
    localparam logic [2:0] S_WALK  = 3'd3;
    localparam logic [2:0] S_FIX   = 3'd4;
    localparam logic [2:0] S_RESP  = 3'd5;

    logic [2:0]               state_reg, state_next;
    logic [CMD_W-1:0]         cmd_reg, cmd_next;
    logic [LW-1:0]            pos_reg, pos_next;
    logic [DATA_W-1:0]        val_reg, val_next;
    logic [SW-1:0]            head_reg, head_next;
    logic [SW-1:0]            free_reg, free_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [CW-1:0]            fresh_reg, fresh_next;
    logic [LW-1:0]            steps_reg, steps_next;
    logic [SW-1:0]            raddr_reg, raddr_next;
    logic                     impl_reg, impl_next;
    logic [SW-1:0]            prev_reg, prev_next;
    logic [SW-1:0]            slot_reg, slot_next;
    logic [SW-1:0]            aux_reg, aux_next;
    logic signed [DATA_W-1:0] rdat_reg, rdat_next;
    logic                     rhit_reg, rhit_next;
    logic [STATUS_W-1:0]      rst_reg, rst_next;

    logic [LW-1:0] count_ext;
    logic [SW-1:0] succ_slot;
    logic [SW-1:0] link_eff;
    logic          issue;
    logic [SW-1:0] issue_addr;

    assign count_ext = LW'(count_reg);
    // slots at or past the fill mark imply the link i+1, wrapping to 0 at the last slot
    assign succ_slot = (raddr_reg == LAST_SLOT) ? '0 : SW'(raddr_reg + 1'b1);
    assign link_eff  = impl_reg ? succ_slot : link_rdata;

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        head_next   = head_reg;
        free_next   = free_reg;
        count_next  = count_reg;
        fresh_next  = fresh_reg;
        steps_next  = steps_reg;
        prev_next   = prev_reg;
        slot_next   = slot_reg;
        aux_next    = aux_reg;
        rdat_next   = rdat_reg;
        rhit_next   = rhit_reg;
        rst_next    = rst_reg;
        issue       = 1'b0;
        issue_addr  = head_reg;
        link_we     = 1'b0;
        link_waddr  = slot_reg;
        link_wdata  = link_eff;
        value_we    = 1'b0;
        value_waddr = free_reg;
        value_wdata = val_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next = cmd;
                    val_next = data_in;
                    case (cmd)
                        CMD_HEAD: pos_next = '0;
                        CMD_TAIL: pos_next = count_ext;
                        default:  pos_next = LW'(position);
                    endcase
                    state_next = S_START;
                end
            end
            S_START:
            begin
                rdat_next  = '0;
                rhit_next  = 1'b0;
                rst_next   = ST_DONE;
                state_next = S_RESP;
                case (cmd_reg)
                    CMD_GET, CMD_DELETE:
                    begin
                        if (pos_reg < count_ext)
                        begin
                            issue      = 1'b1;
                            issue_addr = head_reg;
                            steps_next = pos_reg;
                            state_next = S_WALK;
                        end
                        else
                        begin
                            rst_next = ST_RANGE;
                            if (cmd_reg == CMD_GET)
                            begin
                                rdat_next = MISS_DATA;
                            end
                        end
                    end
                    CMD_HEAD, CMD_TAIL, CMD_INSERT:
                    begin
                        if (pos_reg > count_ext)
                        begin
                            rst_next = ST_RANGE;
                        end
                        else if (count_reg >= FULL_COUNT)
                        begin
                            rst_next = ST_FULL;
                        end
                        else
                        begin
                            issue      = 1'b1;
                            issue_addr = free_reg;
                            state_next = S_POP;
                        end
                    end
                    default:
                    begin
                        rst_next = ST_DONE;
                    end
                endcase
            end
            S_POP:
            begin
                // take the free chain head as the new entry
                free_next   = link_eff;
                slot_next   = free_reg;
                value_we    = 1'b1;
                value_waddr = free_reg;
                value_wdata = val_reg;
                if (impl_reg)
                begin
                    fresh_next = fresh_reg + 1'b1;
                end
                if (pos_reg == '0)
                begin
                    link_we    = 1'b1;
                    link_waddr = free_reg;
                    link_wdata = head_reg;
                    head_next  = free_reg;
                    count_next = count_reg + 1'b1;
                    rhit_next  = 1'b1;
                    state_next = S_RESP;
                end
                else
                begin
                    issue      = 1'b1;
                    issue_addr = head_reg;
                    steps_next = pos_reg - 1'b1;
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (steps_reg != '0)
                begin
                    issue      = 1'b1;
                    issue_addr = link_eff;
                    prev_next  = raddr_reg;
                    steps_next = steps_reg - 1'b1;
                end
                else
                begin
                    case (cmd_reg)
                        CMD_GET:
                        begin
                            rdat_next  = value_rdata;
                            rhit_next  = 1'b1;
                            state_next = S_RESP;
                        end
                        CMD_DELETE:
                        begin
                            slot_next = raddr_reg;
                            if (pos_reg == '0)
                            begin
                                head_next = link_eff;
                            end
                            else
                            begin
                                link_we    = 1'b1;
                                link_waddr = prev_reg;
                                link_wdata = link_eff;
                            end
                            state_next = S_FIX;
                        end
                        default:
                        begin
                            link_we    = 1'b1;
                            link_waddr = slot_reg;
                            link_wdata = link_eff;
                            aux_next   = raddr_reg;
                            state_next = S_FIX;
                        end
                    endcase
                end
            end
            S_FIX:
            begin
                link_we = 1'b1;
                if (cmd_reg == CMD_DELETE)
                begin
                    link_waddr = slot_reg;
                    link_wdata = free_reg;
                    free_next  = slot_reg;
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    link_waddr = aux_reg;
                    link_wdata = slot_reg;
                    count_next = count_reg + 1'b1;
                end
                rhit_next  = 1'b1;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        raddr_next = issue ? issue_addr : raddr_reg;
        impl_next  = issue ? (CW'(issue_addr) >= fresh_reg) : impl_reg;
    end

    assign link_re    = issue;
    assign link_raddr = issue_addr;

    assign in_ready   = (state_reg == S_IDLE);
    assign res_valid  = (state_reg == S_RESP);
    assign res.data   = rdat_reg;
    assign res.hit    = rhit_reg;
    assign res.status = rst_reg;
    assign res.length = count_ext[LEN_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            free_reg  <= '0;
            count_reg <= '0;
            fresh_reg <= '0;
            impl_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            free_reg  <= free_next;
            count_reg <= count_next;
            fresh_reg <= fresh_next;
            impl_reg  <= impl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        pos_reg   <= pos_next;
        val_reg   <= val_next;
        steps_reg <= steps_next;
        raddr_reg <= raddr_next;
        prev_reg  <= prev_next;
        slot_reg  <= slot_next;
        aux_reg   <= aux_next;
        rdat_reg  <= rdat_next;
        rhit_reg  <= rhit_next;
        rst_reg   <= rst_next;
    end

endmodule

>>> src/ile_chk.sv
// ile_chk: port level checks of the indexed list engine, bound to the top
// depends on ile_pkg and indexed_list_engine
module ile_chk
    import ile_pkg::*;
#(
    parameter int CAPACITY = 1024
)(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic signed [DATA_W-1:0] data_out,
    input logic                     hit,
    input logic [STATUS_W-1:0]      status,
    input logic [LEN_W-1:0]         length
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(data_out) && $stable(length))
        else $error("result changed while stalled");

    // one item in flight
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken while busy");

    // a hit is only reported with a done status
    a_hit_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> status == ST_DONE)
        else $error("hit with failing status");

    // a dropped add only happens on a full store
    a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_FULL |-> length == LEN_W'(CAPACITY))
        else $error("store full reported below capacity");

endmodule

bind indexed_list_engine ile_chk #(.CAPACITY(CAPACITY)) u_ile_chk (.*);

>>> tb/list_checker.sv
// list_checker: watches both channels of indexed_list_engine, keeps a shadow
// of the list, predicts each result and compares it field by field
// depends on ile_pkg
module list_checker
    import ile_pkg::*;
#(
    parameter int CAPACITY = 1024
)(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_ready,
    input  logic [CMD_W-1:0]         cmd,
    input  logic [POS_W-1:0]         position,
    input  logic signed [DATA_W-1:0] data_in,
    input  logic                     out_valid,
    input  logic                     out_ready,
    input  logic signed [DATA_W-1:0] data_out,
    input  logic                     hit,
    input  logic [STATUS_W-1:0]      status,
    input  logic [LEN_W-1:0]         length,
    output int                       errors,
    output int                       outstanding
);

    logic signed [DATA_W-1:0] held_values[$];
    res_t                     list_replies[$];

    task automatic apply_list_cmd(
        input  logic [CMD_W-1:0]         c,
        input  logic [POS_W-1:0]         p,
        input  logic signed [DATA_W-1:0] v,
        output res_t                     r
    );
        int n;
        int at;
        n = held_values.size();
        at = int'(p);
        r = '0;
        case (c)
            CMD_GET:
            begin
                if (at < n)
                begin
                    r.data = held_values[at];
                    r.hit = 1'b1;
                end
                else
                begin
                    r.data = MISS_DATA;
                    r.status = ST_RANGE;
                end
            end
            CMD_HEAD, CMD_TAIL, CMD_INSERT:
            begin
                if (c == CMD_HEAD)
                    at = 0;
                else if (c == CMD_TAIL)
                    at = n;
                if (at > n)
                    r.status = ST_RANGE;
                else if (n >= CAPACITY)
                    r.status = ST_FULL;
                else
                    held_values.insert(at, v);
            end
            CMD_DELETE:
            begin
                if (at < n)
                    held_values.delete(at);
                else
                    r.status = ST_RANGE;
            end
            default:
            begin
            end
        endcase
        if (c >= CMD_HEAD && c <= CMD_DELETE)
            r.hit = (r.status == ST_DONE);
        r.length = LEN_W'(held_values.size());
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        res_t got;
        if (!rst_n)
        begin
            held_values.delete();
            list_replies.delete();
            errors <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got.data = data_out;
                got.hit = hit;
                got.status = status;
                got.length = length;
                if (list_replies.size() == 0)
                begin
                    if (errors < 10)
                        $display("result with nothing expected: data %0d hit %0b status %0d length %0d",
                                 got.data, got.hit, got.status, got.length);
                    errors <= errors + 1;
                end
                else
                begin
                    want = list_replies.pop_front();
                    if (got.data !== want.data || got.hit !== want.hit
                        || got.status !== want.status || got.length !== want.length)
                    begin
                        if (errors < 10)
                            $display("mismatch: expected data %0d hit %0b status %0d length %0d, got data %0d hit %0b status %0d length %0d",
                                     want.data, want.hit, want.status, want.length,
                                     got.data, got.hit, got.status, got.length);
                        errors <= errors + 1;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                apply_list_cmd(cmd, position, data_in, want);
                list_replies.push_back(want);
            end
            outstanding <= list_replies.size();
        end
    end

endmodule

>>> tb/testbench.sv
// testbench: drives commands into indexed_list_engine with random idling on
// both channels and gives the verdict from the checker's error count
// depends on ile_pkg, indexed_list_engine, list_checker
module testbench
    import ile_pkg::*;
();

    localparam int CAPACITY       = 1024;
    localparam int RANDOM_ITEMS   = 556;
    localparam int CALM_ITEMS     = 80;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int POS_MAX        = (1 << POS_W) - 1;
    localparam int CMD_MAX        = (1 << CMD_W) - 1;

    logic                     clk;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [CMD_W-1:0]         cmd = CMD_GET;
    logic [POS_W-1:0]         position = '0;
    logic signed [DATA_W-1:0] data_in = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b1;
    logic signed [DATA_W-1:0] data_out;
    logic                     hit;
    logic [STATUS_W-1:0]      status;
    logic [LEN_W-1:0]         length;

    int check_errors;
    int check_waiting;
    int list_len = 0;
    int gap_pct = 15;
    int stall_pct = 12;
    int stall_left = 0;
    int quiet_cycles = 0;
    bit calm = 1'b0;

    indexed_list_engine #(.CAPACITY(CAPACITY)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .cmd(cmd), .position(position), .data_in(data_in),
        .out_valid(out_valid), .out_ready(out_ready),
        .data_out(data_out), .hit(hit), .status(status), .length(length)
    );

    list_checker #(.CAPACITY(CAPACITY)) u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .cmd(cmd), .position(position), .data_in(data_in),
        .out_valid(out_valid), .out_ready(out_ready),
        .data_out(data_out), .hit(hit), .status(status), .length(length),
        .errors(check_errors), .outstanding(check_waiting)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // receiver stalls in bursts of random length
    always @(posedge clk)
    begin
        if (stall_left > 0 && !calm)
            stall_left <= stall_left - 1;
        else if (!calm && $urandom_range(0, 99) < stall_pct)
        begin
            out_ready <= 1'b0;
            stall_left <= $urandom_range(0, 8);
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0: return {1'b1, {(DATA_W-1){1'b0}}};
            1: return {1'b0, {(DATA_W-1){1'b1}}};
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(
        input logic [CMD_W-1:0]         c,
        input int                       p,
        input logic signed [DATA_W-1:0] v
    );
        if (!calm && $urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        position <= p[POS_W-1:0];
        data_in <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        // track the list length to shape later items
        if (c == CMD_HEAD || c == CMD_TAIL)
        begin
            if (list_len < CAPACITY)
                list_len++;
        end
        else if (c == CMD_INSERT)
        begin
            if (p <= list_len && list_len < CAPACITY)
                list_len++;
        end
        else if (c == CMD_DELETE)
        begin
            if (p < list_len)
                list_len--;
        end
    endtask

    task automatic drain_replies();
        in_valid <= 1'b0;
        @(posedge clk);
        while (check_waiting != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int k;
        int pick;
        int p;
        logic [CMD_W-1:0] c;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list corners and unused codes, then a short list built, read and trimmed
        send_item(CMD_GET, 0, pick_value());
        send_item(CMD_DELETE, 0, pick_value());
        send_item(CMD_INSERT, 1, pick_value());
        for (int u = int'(CMD_DELETE) + 1; u <= CMD_MAX; u++)
            send_item(CMD_W'(u), POS_MAX, '1);
        send_item(CMD_HEAD, 0, {1'b0, {(DATA_W-1){1'b1}}});
        send_item(CMD_TAIL, 0, {1'b1, {(DATA_W-1){1'b0}}});
        send_item(CMD_INSERT, 1, '0);
        send_item(CMD_INSERT, 3, '1);
        send_item(CMD_TAIL, POS_MAX, 32'h5a5a_a5a5);
        send_item(CMD_HEAD, CAPACITY, 32'h0123_4567);
        for (int g = 0; g <= 6; g++)
            send_item(CMD_GET, g, pick_value());
        send_item(CMD_GET, POS_MAX, pick_value());
        send_item(CMD_INSERT, POS_MAX, pick_value());
        send_item(CMD_DELETE, 5, pick_value());
        send_item(CMD_DELETE, 2, pick_value());
        send_item(CMD_DELETE, 0, pick_value());
        drain_replies();

        for (k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k % 50 == 0)
            begin
                gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
                stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
            end
            if (k == RANDOM_ITEMS / 2)
                drain_replies();
            calm = (k >= RANDOM_ITEMS - CALM_ITEMS);
            if ($urandom_range(0, 99) < 12)
            begin
                c = CMD_W'($urandom_range(0, CMD_MAX));
                send_item(c, $urandom_range(0, POS_MAX), pick_value());
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (list_len > 48 && pick < 50)
                    pick = 99;
                if (pick < 30)
                    c = CMD_GET;
                else if (pick < 42)
                    c = CMD_HEAD;
                else if (pick < 54)
                    c = CMD_TAIL;
                else if (pick < 74)
                    c = CMD_INSERT;
                else
                    c = CMD_DELETE;
                if (c == CMD_INSERT)
                    p = ($urandom_range(0, 9) == 0) ? list_len + 1
                                                    : $urandom_range(0, list_len);
                else if (list_len == 0 || $urandom_range(0, 9) == 0)
                    p = list_len;
                else
                    p = $urandom_range(0, list_len - 1);
                send_item(c, p, pick_value());
            end
        end

        drain_replies();
        repeat (16) @(posedge clk);
        if (check_errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
